// ===== sv/lfu_pkg.sv =====
// Package for the LFU cache table: entry layout, action codes and fixed widths.
// No dependencies; imported by lfu_cache_table_top.
package lfu_pkg;

  localparam int DATA_W   = 32;
  localparam int CFG_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic [DATA_W-1:0] NO_VALUE  = '1;
  localparam logic [DATA_W-1:0] CNT_MAX   = '1;
  localparam logic              REG_LIMIT = 1'b0;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] cnt;
    logic [DATA_W-1:0] last;
  } entry_t;

endpackage

// ===== sv/lfu_cache_table_top.sv =====
// LFU cache table: CAPACITY-entry key/value store, least-frequently-used eviction.
// A start is taken only while idle; the block then steps through SCAN, DRAIN and UPDATE
// with busy high and registers the result strobe from UPDATE. The one-entry-per-cycle
// scan of the entry memory goes through a single read port and one compare unit.
// Reset (rst_n, synchronous): all entries invalid, stamp clock and held count zero,
// limit register = CAPACITY. Results cannot be stalled by the receiver.
module lfu_cache_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_key,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_write_value,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [lfu_pkg::DATA_W-1:0] out_read_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW = $clog2(CAPACITY + 1);
  localparam int LW = (HW > CFG_W) ? HW : CFG_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CFG_W-1:0] CAP_RST = CFG_W'(CAPACITY);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    cap_r;
  logic                act_r;
  logic [DATA_W-1:0]   key_r, val_r;
  logic [IW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  entry_t              rd_q_r;
  entry_t              mem_r [CAPACITY];

  logic                hit_vld_r, hit_vld_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  entry_t              hit_ent_r, hit_ent_nxt;
  logic                best_vld_r, best_vld_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic [DATA_W-1:0]   best_cnt_r, best_cnt_nxt;
  logic [DATA_W-1:0]   best_last_r, best_last_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;

  logic [CAPACITY-1:0] valid_r, valid_clr, valid_set;
  logic [DATA_W-1:0]   clock_r, clock_nxt;
  logic [HW-1:0]       held_r, held_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0]   out_rv_r, out_rv_nxt;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  logic [LW-1:0]       limit;
  logic                accept, cur_v, evict;
  logic [IW-1:0]       dest;
  logic [DATA_W-1:0]   cnt_inc;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign limit  = (LW'(cap_r) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cap_r);
  assign cur_v  = valid_r[cmp_idx_r];
  assign cnt_inc = (hit_ent_r.cnt == CNT_MAX) ? hit_ent_r.cnt : hit_ent_r.cnt + 1'b1;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_LIMIT) ? PDATA_W'(cap_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = scan_idx_r;
    cmp_vld_nxt   = 1'b0;
    hit_vld_nxt   = hit_vld_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    best_last_nxt = best_last_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    clock_nxt     = clock_r;
    held_nxt      = held_r;
    valid_clr     = '0;
    valid_set     = '0;
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_data       = hit_ent_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_rv_nxt    = out_rv_r;
    evict         = 1'b0;
    dest          = free_idx_r;

    // compare stage on the entry read in the previous cycle
    if (cmp_vld_r) begin
      if (cur_v && (rd_q_r.key == key_r)) begin
        hit_vld_nxt = 1'b1;
        hit_idx_nxt = cmp_idx_r;
        hit_ent_nxt = rd_q_r;
      end
      if (cur_v && (!best_vld_r || (rd_q_r.cnt < best_cnt_r) ||
          ((rd_q_r.cnt == best_cnt_r) && (rd_q_r.last < best_last_r)))) begin
        best_vld_nxt  = 1'b1;
        best_idx_nxt  = cmp_idx_r;
        best_cnt_nxt  = rd_q_r.cnt;
        best_last_nxt = rd_q_r.last;
      end
      if (!cur_v && !free_vld_r) begin
        free_vld_nxt = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          hit_vld_nxt  = 1'b0;
          best_vld_nxt = 1'b0;
          free_vld_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit_vld_r;
        out_rv_nxt    = NO_VALUE;
        if (act_r == ACT_GET) begin
          if (hit_vld_r) begin
            wr_en        = 1'b1;
            wr_data.cnt  = cnt_inc;
            wr_data.last = clock_r + 1'b1;
            clock_nxt    = clock_r + 1'b1;
            out_rv_nxt   = hit_ent_r.data;
          end
        end else if (limit != '0) begin
          if (hit_vld_r) begin
            wr_en        = 1'b1;
            wr_data.cnt  = cnt_inc;
            wr_data.last = clock_r + 1'b1;
            wr_data.data = val_r;
            clock_nxt    = clock_r + 1'b1;
          end else begin
            evict = (LW'(held_r) >= limit) && best_vld_r;
            if (evict) begin
              valid_clr = CAPACITY'(1) << best_idx_r;
              dest = (free_vld_r && (free_idx_r < best_idx_r)) ? free_idx_r : best_idx_r;
            end
            if (evict || free_vld_r) begin
              wr_en        = 1'b1;
              wr_addr      = dest;
              wr_data.key  = key_r;
              wr_data.data = val_r;
              wr_data.cnt  = DATA_W'(1);
              wr_data.last = clock_r + 1'b1;
              clock_nxt    = clock_r + 1'b1;
              valid_set    = CAPACITY'(1) << dest;
              if (!evict) begin
                held_nxt = held_r + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      clock_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RST;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      valid_r     <= (valid_r & ~valid_clr) | valid_set;
      clock_r     <= clock_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_LIMIT)) begin
        cap_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_write_value;
    end
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_vld_r   <= hit_vld_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_ent_r   <= hit_ent_nxt;
    best_vld_r  <= best_vld_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_last_r <= best_last_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    out_hit_r   <= out_hit_nxt;
    out_rv_r    <= out_rv_nxt;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[scan_idx_r];
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rv_r;

endmodule

// ===== sim/lfu_cache_checker.sv =====
`timescale 1ns / 100ps
// Checker for lfu_cache_table_top: watches the command, result and APB channels.
// Predicts each lookup/insert result and compares it with the DUT; depends on lfu_pkg.
module lfu_cache_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_action,
  input  logic [lfu_pkg::DATA_W-1:0]    in_key,
  input  logic [lfu_pkg::DATA_W-1:0]    in_write_value,
  input  logic                          out_valid,
  input  logic                          out_hit,
  input  logic [lfu_pkg::DATA_W-1:0]    out_read_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]   pwdata,
  input  logic                          pready,
  input  logic                          end_of_test,
  output int                            pending_results,
  output int                            fail_count
);
  import lfu_pkg::*;

  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_LIMIT);
  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } access_result_t;

  access_result_t    expected_results[$];
  entry_t            slot_entry [CAPACITY];
  logic              slot_valid [CAPACITY];
  logic [DATA_W-1:0] stamp_clock;
  int                held_count;
  logic [CFG_W-1:0]  limit_reg;
  int                failures = 0;
  logic              end_checked = 1'b0;

  assign fail_count = failures;

  task automatic report_mismatch(input string what);
    if (failures < REPORT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
    failures++;
  endtask

  function automatic void touch_slot(int s);
    if (slot_entry[s].cnt != CNT_MAX) slot_entry[s].cnt = slot_entry[s].cnt + 1'b1;
    stamp_clock = stamp_clock + 1'b1;
    slot_entry[s].last = stamp_clock;
  endfunction

  function automatic access_result_t predict_access(logic act, logic [DATA_W-1:0] k,
                                                    logic [DATA_W-1:0] v);
    int             eff_limit;
    int             found;
    int             victim;
    int             free_idx;
    access_result_t res;
    eff_limit = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
    found = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (found < 0 && slot_valid[i] && slot_entry[i].key == k) found = i;
    res.hit = (found >= 0);
    res.read_value = NO_VALUE;
    if (act == ACT_GET) begin
      if (found >= 0) begin
        touch_slot(found);
        res.read_value = slot_entry[found].data;
      end
    end else if (eff_limit != 0) begin
      if (found >= 0) begin
        touch_slot(found);
        slot_entry[found].data = v;
      end else begin
        if (held_count >= eff_limit) begin
          victim = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_valid[i] && (victim < 0 ||
                slot_entry[i].cnt < slot_entry[victim].cnt ||
                (slot_entry[i].cnt == slot_entry[victim].cnt &&
                 slot_entry[i].last < slot_entry[victim].last)))
              victim = i;
          end
          if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            held_count--;
          end
        end
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (free_idx < 0 && !slot_valid[i]) free_idx = i;
        if (free_idx >= 0) begin
          stamp_clock = stamp_clock + 1'b1;
          slot_valid[free_idx] = 1'b1;
          slot_entry[free_idx].key = k;
          slot_entry[free_idx].data = v;
          slot_entry[free_idx].cnt = 1;
          slot_entry[free_idx].last = stamp_clock;
          held_count++;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_valid[i] = 1'b0;
        slot_entry[i] = '0;
      end
      stamp_clock = '0;
      held_count = 0;
      limit_reg = CFG_W'(CAPACITY);
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        limit_reg = pwdata[CFG_W-1:0];
      if (start && !busy)
        expected_results.push_back(predict_access(in_action, in_key, in_write_value));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result hit=%0b value=%h",
                                    out_hit, out_read_value));
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", out_hit, want.hit));
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_read_value, want.read_value));
        end
      end
      if (end_of_test && !end_checked) begin
        end_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== sim/lfu_cache_table_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for lfu_cache_table_top: clock, reset, get/put commands and limit writes.
// Checking is done by lfu_cache_checker; depends on lfu_pkg and the DUT.
module lfu_cache_table_top_tb;
  import lfu_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int LATENCY         = CAPACITY + 3;
  localparam int STALL_LIMIT     = 600;
  localparam int KEY_POOL        = 24;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int NUM_PHASES      = 10;
  localparam int QUIET_PHASE     = 8;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_LIMIT);

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_action;
  logic signed [DATA_W-1:0]  in_key;
  logic signed [DATA_W-1:0]  in_write_value;
  logic                      out_valid;
  logic                      out_hit;
  logic signed [DATA_W-1:0]  out_read_value;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      end_of_test;
  int                        pending_results;
  int                        fail_count;
  int                        stall_cycles = 0;
  logic                      idle_en;
  logic [DATA_W-1:0]         key_pool [KEY_POOL];
  logic [CFG_W-1:0]          phase_limit [NUM_PHASES] = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd5,
                                                          5'd17, 5'd3, 5'd8, 5'd16, 5'd12};

  lfu_cache_table_top #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_key(in_key), .in_write_value(in_write_value),
    .out_valid(out_valid), .out_hit(out_hit), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lfu_cache_checker #(.CAPACITY(CAPACITY)) lfu_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_key(in_key), .in_write_value(in_write_value),
    .out_valid(out_valid), .out_hit(out_hit), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .end_of_test(end_of_test),
    .pending_results(pending_results), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] v);
    int gap;
    if (idle_en && $urandom_range(99) < 11) begin
      gap = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_write_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0 || busy);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    logic [PDATA_W-1:0] noise;
    noise = $urandom;
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {noise[PDATA_W-1:CFG_W], lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int span;
    int eff;
    logic act;
    logic [DATA_W-1:0] k;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_GET;
    in_key <= '0;
    in_write_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    end_of_test <= 1'b0;
    idle_en = 1'b1;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: empty miss, extreme keys/values, hits, update, fill, evict
    send_item(ACT_GET, 32'h0000_0000, $urandom);
    send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'h7FFF_FFFF, $urandom);
    send_item(ACT_GET, 32'h8000_0000, $urandom);
    send_item(ACT_GET, 32'h0000_0000, $urandom);
    send_item(ACT_GET, 32'hFFFF_FFFF, $urandom);
    send_item(ACT_PUT, 32'h0000_0000, 32'h1234_5678);
    send_item(ACT_GET, 32'h0000_0000, $urandom);
    send_item(ACT_GET, 32'h0000_0005, $urandom);
    for (int i = 0; i < 12; i++) send_item(ACT_PUT, 100 + i, $urandom);
    send_item(ACT_GET, 100, $urandom);
    // full: lowest count, oldest stamp goes
    send_item(ACT_PUT, 200, $urandom);
    send_item(ACT_GET, 101, $urandom);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      idle_en = (p != QUIET_PHASE);
      eff = (phase_limit[p] > CAPACITY) ? CAPACITY : int'(phase_limit[p]);
      span = (eff + 6 > KEY_POOL) ? KEY_POOL : eff + 6;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        act = ($urandom_range(99) < 45) ? ACT_PUT : ACT_GET;
        k = ($urandom_range(99) < 8) ? $urandom : key_pool[$urandom_range(span - 1)];
        send_item(act, k, $urandom);
      end
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
